// ===== rtl/core/swpc_pkg.sv =====
// Shared types and constants for the soil watering pump controller.
`default_nettype none

package swpc_pkg;

    // Width of the millisecond time counters, default value.
    localparam int TIME_BITS_DEFAULT = 32;

    // Field and register widths.
    localparam int MOIST_BITS   = 7;
    localparam int PERIOD_BITS  = 24;
    localparam int CFG_DATA_BITS = 24;
    localparam int CFG_IDX_BITS = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_MOISTURE_LOW    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MOISTURE_HIGH   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SAMPLE_PERIOD   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_RUN_TIME    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_COOLDOWN_TIME   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_MANUAL_RUN_TIME = 3'd5;

    // Configuration reset values.
    localparam logic [MOIST_BITS-1:0]  MOISTURE_LOW_RESET    = 7'd30;
    localparam logic [MOIST_BITS-1:0]  MOISTURE_HIGH_RESET   = 7'd70;
    localparam logic [PERIOD_BITS-1:0] SAMPLE_PERIOD_RESET   = 24'd1000;
    localparam logic [PERIOD_BITS-1:0] MAX_RUN_TIME_RESET    = 24'd10000;
    localparam logic [PERIOD_BITS-1:0] COOLDOWN_TIME_RESET   = 24'd30000;
    localparam logic [PERIOD_BITS-1:0] MANUAL_RUN_TIME_RESET = 24'd5000;

    // Held moisture value before the first sensor latch.
    localparam logic [MOIST_BITS-1:0] HELD_MOISTURE_RESET = 7'd45;

    // LED status codes.
    localparam logic [1:0] LED_ALL_CLEAR  = 2'd0;
    localparam logic [1:0] LED_PUMP_ACTIVE = 2'd1;
    localparam logic [1:0] LED_LOW      = 2'd2;
    localparam logic [1:0] LED_SENSOR   = 2'd3;

    // Configuration register set as seen by the control logic.
    typedef struct packed {
        logic [MOIST_BITS-1:0]  moisture_low;
        logic [MOIST_BITS-1:0]  moisture_high;
        logic [PERIOD_BITS-1:0] sample_period;
        logic [PERIOD_BITS-1:0] max_run_time;
        logic [PERIOD_BITS-1:0] cooldown_time;
        logic [PERIOD_BITS-1:0] manual_run_time;
    } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/swpc_cfg_regs.sv =====
// Configuration register file of the soil watering pump controller.
`default_nettype none

module swpc_cfg_regs
    import swpc_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_write,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    output cfg_t                          cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MOISTURE_LOW:    cfg_next.moisture_low    = cfg_data[MOIST_BITS-1:0];
                REG_MOISTURE_HIGH:   cfg_next.moisture_high   = cfg_data[MOIST_BITS-1:0];
                REG_SAMPLE_PERIOD:   cfg_next.sample_period   = cfg_data[PERIOD_BITS-1:0];
                REG_MAX_RUN_TIME:    cfg_next.max_run_time    = cfg_data[PERIOD_BITS-1:0];
                REG_COOLDOWN_TIME:   cfg_next.cooldown_time   = cfg_data[PERIOD_BITS-1:0];
                REG_MANUAL_RUN_TIME: cfg_next.manual_run_time = cfg_data[PERIOD_BITS-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.moisture_low    <= MOISTURE_LOW_RESET;
            cfg_reg.moisture_high   <= MOISTURE_HIGH_RESET;
            cfg_reg.sample_period   <= SAMPLE_PERIOD_RESET;
            cfg_reg.max_run_time    <= MAX_RUN_TIME_RESET;
            cfg_reg.cooldown_time   <= COOLDOWN_TIME_RESET;
            cfg_reg.manual_run_time <= MANUAL_RUN_TIME_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/core/swpc_elapsed.sv =====
// Elapsed-time check: has a limit passed since a recorded time, with clamping.
`default_nettype none

module swpc_elapsed
    import swpc_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEFAULT
)
(
    input  wire logic [TIME_BITS-1:0]   now,
    input  wire logic [TIME_BITS-1:0]   then_time,
    input  wire logic [PERIOD_BITS-1:0] limit,
    output logic                        reached
);

    localparam int CMP_BITS = (TIME_BITS > PERIOD_BITS) ? TIME_BITS : PERIOD_BITS;

    logic [TIME_BITS-1:0] diff;

    assign diff = now - then_time;

    // A recorded time later than now counts as zero elapsed.
    always_comb
    begin
        if (now >= then_time)
            reached = CMP_BITS'(diff) >= CMP_BITS'(limit);
        else
            reached = (limit == '0);
    end

endmodule

`default_nettype wire

// ===== rtl/core/swpc_core.sv =====
// Controller state and the per-tick update of mode, sensor latch and pump.
`default_nettype none

module swpc_core
    import swpc_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEFAULT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  cfg_t                       cfg,
    input  wire logic                  toggle_press,
    input  wire logic                  water_press,
    input  wire logic [MOIST_BITS-1:0] moisture_now,
    input  wire logic                  sensor_good,
    output logic                       pump_drive,
    output logic                       manual_mode,
    output logic [1:0]                 led_code
);

    logic [TIME_BITS-1:0]  time_now_reg,          time_now_next;
    logic [TIME_BITS-1:0]  last_sample_reg,       last_sample_next;
    logic [TIME_BITS-1:0]  pump_start_reg,        pump_start_next;
    logic [TIME_BITS-1:0]  pump_end_reg,          pump_end_next;
    logic [TIME_BITS-1:0]  manual_start_reg,      manual_start_next;
    logic [MOIST_BITS-1:0] held_moisture_reg,     held_moisture_next;
    logic                  held_ok_reg,           held_ok_next;
    logic                  mode_manual_reg,       mode_manual_next;
    logic                  pump_running_reg,      pump_running_next;
    logic                  session_reg,           session_next;

    // Values after the button stage.
    logic                 btn_mode;
    logic                 btn_running;
    logic                 btn_session;
    logic [TIME_BITS-1:0] btn_pump_start;
    logic [TIME_BITS-1:0] btn_pump_end;
    logic [TIME_BITS-1:0] btn_manual_start;

    logic sample_due;
    logic cooldown_done;
    logic max_run_done;
    logic manual_done;

    // Buttons: toggle first, then the manual press.
    always_comb
    begin
        btn_mode         = mode_manual_reg ^ toggle_press;
        btn_running      = pump_running_reg;
        btn_pump_end     = pump_end_reg;
        btn_pump_start   = pump_start_reg;
        btn_session      = session_reg;
        btn_manual_start = manual_start_reg;
        if (toggle_press && btn_mode)
        begin
            if (pump_running_reg)
                btn_pump_end = time_now_reg;
            btn_running = 1'b0;
        end
        if (water_press && btn_mode)
        begin
            btn_session      = 1'b1;
            btn_manual_start = time_now_reg;
            btn_running      = 1'b1;
            btn_pump_start   = time_now_reg;
        end
    end

    swpc_elapsed #(.TIME_BITS(TIME_BITS)) u_sample (
        .now       (time_now_reg),
        .then_time (last_sample_reg),
        .limit     (cfg.sample_period),
        .reached   (sample_due)
    );

    swpc_elapsed #(.TIME_BITS(TIME_BITS)) u_cooldown (
        .now       (time_now_reg),
        .then_time (btn_pump_end),
        .limit     (cfg.cooldown_time),
        .reached   (cooldown_done)
    );

    swpc_elapsed #(.TIME_BITS(TIME_BITS)) u_max_run (
        .now       (time_now_reg),
        .then_time (btn_pump_start),
        .limit     (cfg.max_run_time),
        .reached   (max_run_done)
    );

    swpc_elapsed #(.TIME_BITS(TIME_BITS)) u_manual (
        .now       (time_now_reg),
        .then_time (btn_manual_start),
        .limit     (cfg.manual_run_time),
        .reached   (manual_done)
    );

    // Sensor latch, then the auto or manual pump control.
    always_comb
    begin
        logic turn_off;

        turn_off           = 1'b0;
        time_now_next      = time_now_reg + {{(TIME_BITS-1){1'b0}}, 1'b1};
        mode_manual_next   = btn_mode;
        session_next       = btn_session;
        manual_start_next  = btn_manual_start;
        pump_running_next  = btn_running;
        pump_start_next    = btn_pump_start;
        pump_end_next      = btn_pump_end;
        last_sample_next   = last_sample_reg;
        held_moisture_next = held_moisture_reg;
        held_ok_next       = held_ok_reg;

        if (sample_due)
        begin
            last_sample_next   = time_now_reg;
            held_moisture_next = moisture_now;
            held_ok_next       = sensor_good;
        end

        if (!btn_mode)
        begin
            if (!held_ok_next)
                turn_off = 1'b1;
            else if (!btn_running)
            begin
                if ((held_moisture_next < cfg.moisture_low) && cooldown_done)
                begin
                    pump_running_next = 1'b1;
                    pump_start_next   = time_now_reg;
                end
            end
            else if (max_run_done || (held_moisture_next >= cfg.moisture_high))
                turn_off = 1'b1;
        end
        else if (btn_session)
        begin
            if (manual_done)
            begin
                session_next = 1'b0;
                turn_off     = 1'b1;
            end
        end
        else
            turn_off = 1'b1;

        if (turn_off)
        begin
            if (btn_running)
                pump_end_next = time_now_reg;
            pump_running_next = 1'b0;
        end

        pump_drive  = pump_running_next;
        manual_mode = btn_mode;
        priority if (!held_ok_next)
            led_code = LED_SENSOR;
        else if (pump_running_next)
            led_code = LED_PUMP_ACTIVE;
        else if (held_moisture_next < cfg.moisture_low)
            led_code = LED_LOW;
        else
            led_code = LED_ALL_CLEAR;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_now_reg      <= '0;
            last_sample_reg   <= '0;
            pump_start_reg    <= '0;
            pump_end_reg      <= '0;
            manual_start_reg  <= '0;
            held_moisture_reg <= HELD_MOISTURE_RESET;
            held_ok_reg       <= 1'b1;
            mode_manual_reg   <= 1'b0;
            pump_running_reg  <= 1'b0;
            session_reg       <= 1'b0;
        end
        else if (step)
        begin
            time_now_reg      <= time_now_next;
            last_sample_reg   <= last_sample_next;
            pump_start_reg    <= pump_start_next;
            pump_end_reg      <= pump_end_next;
            manual_start_reg  <= manual_start_next;
            held_moisture_reg <= held_moisture_next;
            held_ok_reg       <= held_ok_next;
            mode_manual_reg   <= mode_manual_next;
            pump_running_reg  <= pump_running_next;
            session_reg       <= session_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/soil_watering_pump_controller_unit.sv =====
// Top level of the soil watering pump controller: input and result registers.
//
//   Channel   Handshake               Payload
//   -------   ---------------------   -------------------------------------------
//   in        in_valid / in_stall     toggle_press, water_press, moisture_now,
//                                     sensor_good (one millisecond tick per beat)
//   out       out_valid / out_stall   pump_drive, manual_mode, led_code
//   cfg       cfg_write               cfg_index, cfg_data (write only)
//
// Each tick beat is captured in an input register. When the result register is
// free or being emptied, the controller state is updated and the result is
// written to the output register.
// One tick is taken every cycle while the output is not stalled; the single
// update path through the state registers sets this rate. A stall on the output
// holds the result register, and the input register then holds its beat and
// raises in_stall. Reset is asynchronous and active low and returns the
// controller state, configuration and valid flags to their reset values; the
// input and result data registers are not reset, and there is no clearing pass.
`default_nettype none

module soil_watering_pump_controller_unit
    import swpc_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEFAULT
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,

    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic                     toggle_press,
    input  wire logic                     water_press,
    input  wire logic [MOIST_BITS-1:0]    moisture_now,
    input  wire logic                     sensor_good,

    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic                          pump_drive,
    output logic                          manual_mode,
    output logic [1:0]                    led_code,

    input  wire logic                     cfg_write,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

    cfg_t cfg;

    // Input register.
    logic                  in_valid_reg;
    logic                  toggle_reg;
    logic                  water_reg;
    logic [MOIST_BITS-1:0] moisture_reg;
    logic                  good_reg;

    // Result register.
    logic                  out_valid_reg;
    logic                  pump_reg;
    logic                  mode_reg;
    logic [1:0]            led_reg;

    logic                  step;
    logic                  in_take;
    logic                  res_pump;
    logic                  res_mode;
    logic [1:0]            res_led;

    // A tick is processed when the result register is free or being emptied.
    assign step     = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !step;
    assign in_take  = in_valid && !in_stall;

    swpc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    swpc_core #(.TIME_BITS(TIME_BITS)) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .cfg          (cfg),
        .toggle_press (toggle_reg),
        .water_press  (water_reg),
        .moisture_now (moisture_reg),
        .sensor_good  (good_reg),
        .pump_drive   (res_pump),
        .manual_mode  (res_mode),
        .led_code     (res_led)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (step)
                in_valid_reg <= 1'b0;

            if (step)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            toggle_reg   <= toggle_press;
            water_reg    <= water_press;
            moisture_reg <= moisture_now;
            good_reg     <= sensor_good;
        end
        if (step)
        begin
            pump_reg <= res_pump;
            mode_reg <= res_mode;
            led_reg  <= res_led;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pump_drive  = pump_reg;
    assign manual_mode = mode_reg;
    assign led_code    = led_reg;

endmodule

`default_nettype wire
